// ===== rtl/core/fea_pkg.sv =====
// Shared constants, codes and types of the free extent allocator.
package fea_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int ADDR_W      = 24;
    localparam int FIELD_W     = 24;
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    localparam int STAT_W      = 2;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    localparam logic [ADDR_W-1:0]  ADDR_MAX   = '1;
    localparam logic [FIELD_W-1:0] POOL_RESET = '1;

    // register index, taken from paddr[2]
    localparam logic REG_POOL_SIZE = 1'b0;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // where the anchor cell of an update comes from
    typedef enum logic [1:0] {
        SRC_CAND,   // first cell whose candidate flag is set
        SRC_HEAD,   // virtual slot in front of cell 0
        SRC_LAST    // last occupied cell
    } t_src;

    // update applied around the anchor
    typedef enum logic [3:0] {
        K_NONE,
        K_DROP,     // remove anchor
        K_TRIM_R,   // anchor end := s
        K_TRIM_L,   // anchor start := e
        K_SPLIT,    // anchor end := s, new [e, old end) after it
        K_PRE_NXT,  // cell after anchor start := s
        K_GROW_R,   // anchor end := e
        K_JOIN,     // anchor end := next end, next removed
        K_INS       // new [s, e) after anchor
    } t_kind;

    typedef struct packed {
        logic cand;
        logic s_eq_s;
        logic ge_end;
        logic s_eq_e;
        logic e_eq_n;
        logic lt_s;
        logic e_eq_s;
    } t_flags;

    // left to right link
    typedef struct packed {
        logic              sel;
        logic              past;
        logic              gt;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] stop;
    } t_lnk_r;

    // right to left link
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] stop;
    } t_lnk_l;

    typedef struct packed {
        logic              load;
        logic [ADDR_W-1:0] load_end;
        t_cmd              cmd;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] e;
        t_src              src;
        t_kind             kind;
    } t_cell_ctl;

endpackage

// ===== rtl/core/fea_req_if.sv =====
// Request channel: command and range of one transaction.
interface fea_req_if import fea_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [FIELD_W-1:0] start_req;
    logic [FIELD_W-1:0] length;

    modport source (output valid, output cmd, output start_req, output length, input ready);
    modport sink   (input valid, input cmd, input start_req, input length, output ready);
endinterface

// ===== rtl/core/fea_rsp_if.sv =====
// Response channel: status and extent count of one transaction.
interface fea_rsp_if import fea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  extent_count;

    modport source (output valid, output status, output extent_count, input ready);
    modport sink   (input valid, input status, input extent_count, output ready);
endinterface

// ===== rtl/core/free_extent_allocator.sv =====
// Top level of the free extent allocator: control, config register and cell chain.
//
//   channel   dir  handshake              payload
//   i_req     in   valid/ready            cmd, start_req, length
//   o_rsp     out  valid/ready            status, extent_count
//   apb       in   psel/penable/pready    paddr, pwdata, prdata (pool_size at 0)
//
// A transaction registers per-cell compares in the compare state; the update state
// ripples the anchor select along the 64-cell chain and moves the cells. Requests
// wait for the update to complete. A held response stalls the update until taken.
// Synchronous reset loads cell 0 with the whole pool; no clearing pass.
// Writing pool_size reloads the table the same way.
module free_extent_allocator import fea_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fea_req_if.sink            i_req,
    fea_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [FIELD_W-1:0] r_pool;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status;
    logic [CNT_W-1:0]   r_out_count;

    t_cmd               r_cmd;
    logic [ADDR_W-1:0]  r_s, r_e;
    logic               r_zero;

    logic [ADDR_W-1:0]  in_s, in_len, room, in_e;
    logic               in_over, in_fire, cfg_wr, done, full;
    t_src               src;
    t_kind              act;
    t_status            stat;
    t_cell_ctl          ctl;
    logic               any_cand;
    t_flags             head_f, sel_f;

    // ---- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_SIZE);
    assign prdata = (paddr[2] == REG_POOL_SIZE) ? DATA_W'(r_pool) : '0;

    // ---- request clipping: no range reaches past the last address
    assign in_s    = i_req.start_req[ADDR_W-1:0];
    assign in_len  = i_req.length[ADDR_W-1:0];
    assign room    = ADDR_MAX - in_s;
    assign in_over = (in_len > room);
    assign in_e    = in_over ? ADDR_MAX : ADDR_W'(in_s + in_len);
    assign in_fire = i_req.valid && i_req.ready;

    // ---- decision
    always_comb begin
        full = (r_used == CNT_W'(MAX_EXTENTS));

        if (r_cmd == CMD_ALLOC)       src = SRC_CAND;
        else if (r_used == '0)        src = SRC_HEAD;
        else if (head_f.lt_s)         src = SRC_HEAD;
        else if (any_cand)            src = SRC_CAND;
        else                          src = SRC_LAST;

        act  = K_NONE;
        stat = ST_DONE;
        if (!r_zero) begin
            if (r_cmd == CMD_ALLOC) begin
                if (!any_cand)                         stat = ST_MISS;
                else if (sel_f.s_eq_s && sel_f.ge_end) act  = K_DROP;
                else if (sel_f.ge_end)                 act  = K_TRIM_R;
                else if (sel_f.s_eq_s)                 act  = K_TRIM_L;
                else if (full)                         stat = ST_FULL;
                else                                   act  = K_SPLIT;
            end else begin
                unique case (src)
                    SRC_HEAD: begin
                        if (r_used != '0 && head_f.e_eq_s) act  = K_PRE_NXT;
                        else if (full)                     stat = ST_FULL;
                        else                               act  = K_INS;
                    end
                    SRC_CAND: begin
                        if (sel_f.s_eq_e && sel_f.e_eq_n) act  = K_JOIN;
                        else if (sel_f.s_eq_e)            act  = K_GROW_R;
                        else if (sel_f.e_eq_n)            act  = K_PRE_NXT;
                        else if (full)                    stat = ST_FULL;
                        else                              act  = K_INS;
                    end
                    SRC_LAST: begin
                        if (sel_f.s_eq_e) act  = K_GROW_R;
                        else if (full)    stat = ST_FULL;
                        else              act  = K_INS;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---- state machine
    always_comb begin
        done        = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_used      = r_used;

        unique case (r_state)
            S_IDLE: i_req.ready = 1'b1;
            S_CMP:  i_req.ready = 1'b0;
            S_UPD:  i_req.ready = done;
            default: i_req.ready = 1'b0;
        endcase

        unique case (r_state)
            S_IDLE: if (in_fire) n_state = S_CMP;
            S_CMP:  n_state = S_UPD;
            S_UPD: begin
                if (done) n_state = in_fire ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (done) begin
            n_out_valid = 1'b1;
            case (act)
                K_DROP, K_JOIN: n_used = r_used - CNT_W'(1);
                K_SPLIT, K_INS: n_used = r_used + CNT_W'(1);
                default:        n_used = r_used;
            endcase
        end
        if (cfg_wr) n_used = (pwdata[FIELD_W-1:0] == '0) ? '0 : CNT_W'(1);
    end

    always_comb begin
        ctl.load     = !i_rst_n || cfg_wr;
        ctl.load_end = !i_rst_n ? POOL_RESET[ADDR_W-1:0] : pwdata[ADDR_W-1:0];
        ctl.cmd      = r_cmd;
        ctl.s        = r_s;
        ctl.e        = r_e;
        ctl.src      = src;
        ctl.kind     = done ? act : K_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= CNT_W'(1);
            r_pool      <= POOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (cfg_wr) r_pool <= pwdata[FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= t_cmd'(i_req.cmd);
            r_s    <= in_s;
            r_e    <= in_e;
            r_zero <= (in_len == '0) || (room == '0);
        end
        if (done) begin
            r_out_status <= stat;
            r_out_count  <= n_used;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.extent_count = r_out_count;

    fea_chain u_chain (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_used       (r_used),
        .o_any_cand   (any_cand),
        .o_head_flags (head_f),
        .o_sel_flags  (sel_f)
    );

`ifndef NO_ASSERTIONS
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_EXTENTS))
        else $error("extent count above table size");

    a_fire_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_CMP)
        else $error("accepted transaction did not enter compare");

    a_cmp_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |=> r_state == S_UPD)
        else $error("compare not followed by update");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> o_rsp.extent_count == CNT_W'(MAX_EXTENTS))
        else $error("table full reported below capacity");

    a_used_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!done && !cfg_wr) |=> $stable(r_used))
        else $error("extent count moved without an update");
`endif

endmodule

// ===== rtl/core/fea_cell.sv =====
// One extent cell: holds [start, stop), compares, and moves with its neighbors.
module fea_cell import fea_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_lnk_r    i_left,
    input  t_lnk_l    i_right,
    output t_lnk_r    o_right,
    output t_lnk_l    o_left,
    output t_flags    o_flags,
    output t_flags    o_sel_flags
);

    logic [ADDR_W-1:0] r_start, n_start;
    logic [ADDR_W-1:0] r_stop,  n_stop;
    t_flags            r_flags, n_flags;
    logic              hit, gap, sel, gt, nxt, gt1;

    always_comb begin
        hit = i_valid && (i_ctl.s >= r_start) && (i_ctl.s < r_stop);
        gap = i_valid && i_right.valid && (i_ctl.s >= r_stop) && (i_ctl.s < i_right.start);

        n_flags.cand   = (i_ctl.cmd == CMD_FREE) ? gap : hit;
        n_flags.s_eq_s = (i_ctl.s == r_start);
        n_flags.ge_end = (i_ctl.e >= r_stop);
        n_flags.s_eq_e = (i_ctl.s == r_stop);
        n_flags.e_eq_n = (i_ctl.e == i_right.start);
        n_flags.lt_s   = (i_ctl.s < r_start);
        n_flags.e_eq_s = (i_ctl.e == r_start);

        unique case (i_ctl.src)
            SRC_CAND: sel = r_flags.cand && !i_left.past;
            SRC_LAST: sel = i_valid && !i_right.valid;
            SRC_HEAD: sel = 1'b0;
            default:  sel = 1'b0;
        endcase

        gt  = i_left.past;  // anchor lies left of this cell
        nxt = i_left.sel;   // anchor is the left neighbor
        gt1 = i_left.gt;    // anchor lies two or more cells to the left

        n_start = r_start;
        n_stop  = r_stop;
        if (i_ctl.load) begin
            n_start = '0;
            n_stop  = i_ctl.load_end;
        end else begin
            case (i_ctl.kind)
                K_DROP: begin
                    if (sel || gt) begin
                        n_start = i_right.start;
                        n_stop  = i_right.stop;
                    end
                end
                K_TRIM_R: begin
                    if (sel) n_stop = i_ctl.s;
                end
                K_TRIM_L: begin
                    if (sel) n_start = i_ctl.e;
                end
                K_SPLIT: begin
                    if (sel) begin
                        n_stop = i_ctl.s;
                    end else if (nxt) begin
                        n_start = i_ctl.e;
                        n_stop  = i_left.stop;
                    end else if (gt1) begin
                        n_start = i_left.start;
                        n_stop  = i_left.stop;
                    end
                end
                K_PRE_NXT: begin
                    if (nxt) n_start = i_ctl.s;
                end
                K_GROW_R: begin
                    if (sel) n_stop = i_ctl.e;
                end
                K_JOIN: begin
                    if (sel) begin
                        n_stop = i_right.stop;
                    end else if (gt) begin
                        n_start = i_right.start;
                        n_stop  = i_right.stop;
                    end
                end
                K_INS: begin
                    if (nxt) begin
                        n_start = i_ctl.s;
                        n_stop  = i_ctl.e;
                    end else if (gt1) begin
                        n_start = i_left.start;
                        n_stop  = i_left.stop;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_stop  <= n_stop;
        r_flags <= n_flags;
    end

    assign o_right     = '{sel: sel, past: i_left.past || sel, gt: i_left.past,
                           start: r_start, stop: r_stop};
    assign o_left      = '{valid: i_valid, start: r_start, stop: r_stop};
    assign o_flags     = r_flags;
    assign o_sel_flags = sel ? r_flags : '0;

endmodule

// ===== rtl/core/fea_chain.sv =====
// Row of extent cells, sorted by start, with the reductions the control needs.
module fea_chain import fea_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_used,
    output logic             o_any_cand,
    output t_flags           o_head_flags,
    output t_flags           o_sel_flags
);

    t_lnk_r w_lr [MAX_EXTENTS+1];
    t_lnk_l w_rl [MAX_EXTENTS+1];
    t_flags w_flags [MAX_EXTENTS];
    t_flags w_sel   [MAX_EXTENTS];
    logic   [MAX_EXTENTS-1:0] w_valid;
    logic   head;
    logic   [$bits(t_flags)-1:0] sel_acc;
    logic   cand_acc;

    assign head                = (i_ctl.src == SRC_HEAD);
    assign w_lr[0]             = '{sel: head, past: head, gt: 1'b0, start: '0, stop: '0};
    assign w_rl[MAX_EXTENTS]   = '0;

    for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
        assign w_valid[k] = (CNT_W'(k) < i_used);

        fea_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_valid     (w_valid[k]),
            .i_left      (w_lr[k]),
            .i_right     (w_rl[k+1]),
            .o_right     (w_lr[k+1]),
            .o_left      (w_rl[k]),
            .o_flags     (w_flags[k]),
            .o_sel_flags (w_sel[k])
        );
    end

    always_comb begin
        sel_acc  = '0;
        cand_acc = 1'b0;
        for (int k = 0; k < MAX_EXTENTS; k++) begin
            sel_acc  = sel_acc | w_sel[k];
            cand_acc = cand_acc | w_flags[k].cand;
        end
    end

    assign o_any_cand   = cand_acc;
    assign o_sel_flags  = sel_acc;
    assign o_head_flags = w_flags[0];

endmodule

// ===== tb/free_extent_allocator_tb.sv =====
// Self-checking testbench of the free extent allocator: directed paths, full table, random mixes.
`timescale 1ns / 100ps

module free_extent_allocator_tb;
    import fea_pkg::*;

    localparam int                 FIELD_MAX      = (1 << FIELD_W) - 1;
    localparam logic [PADDR_W-1:0] POOL_SIZE_ADDR = {REG_POOL_SIZE, 2'b00};

    typedef logic [ADDR_W:0] t_span;

    typedef struct {
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_reply;

    // range the stimulus took out of the pool and may give back later
    typedef struct {
        int base;
        int size;
    } t_held;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    fea_req_if req_bus ();
    fea_rsp_if rsp_bus ();

    free_extent_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted free table
    t_span   free_start [MAX_EXTENTS];
    t_span   free_len   [MAX_EXTENTS];
    int      free_used;

    t_reply  replies_due [$];
    t_held   held_ranges [$];
    t_status last_status;
    int      pool_now;
    bit      calm_run;
    int      n_fail;
    int      n_items;
    int      n_checked;
    int      n_settings;
    int      status_tally [3];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("free_extent_allocator_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void table_load(input logic [FIELD_W-1:0] pool);
        for (int k = 0; k < MAX_EXTENTS; k++) begin
            free_start[k] = '0;
            free_len[k]   = '0;
        end
        if (pool == '0) begin
            free_used = 0;
        end else begin
            free_len[0] = (t_span'(pool) > t_span'(ADDR_MAX)) ? t_span'(ADDR_MAX) : t_span'(pool);
            free_used   = 1;
        end
    endfunction

    function automatic bit table_insert(input int pos, input t_span s, input t_span n);
        if (free_used >= MAX_EXTENTS || pos > free_used) return 1'b0;
        for (int k = free_used; k > pos; k--) begin
            free_start[k] = free_start[k-1];
            free_len[k]   = free_len[k-1];
        end
        free_start[pos] = s;
        free_len[pos]   = n;
        free_used++;
        return 1'b1;
    endfunction

    function automatic void table_remove(input int pos);
        if (pos >= free_used) return;
        for (int k = pos; k + 1 < free_used; k++) begin
            free_start[k] = free_start[k+1];
            free_len[k]   = free_len[k+1];
        end
        free_used--;
        free_start[free_used] = '0;
        free_len[free_used]   = '0;
    endfunction

    function automatic t_status table_alloc(input t_span s, input t_span n);
        t_span lo;
        t_span hi;
        t_span e;
        for (int i = 0; i < free_used; i++) begin
            lo = free_start[i];
            hi = lo + free_len[i];
            if (s >= lo && s < hi) begin
                e = s + n;
                if (e > hi) e = hi;
                if (s == lo && e == hi) begin
                    table_remove(i);
                end else if (e == hi) begin
                    free_len[i] = s - lo;
                end else if (s == lo) begin
                    free_start[i] = e;
                    free_len[i]   = hi - e;
                end else begin
                    if (!table_insert(i + 1, e, hi - e)) return ST_FULL;
                    free_len[i] = s - lo;
                end
                return ST_DONE;
            end
        end
        return ST_MISS;
    endfunction

    function automatic t_status table_free(input t_span s, input t_span n);
        t_span lo;
        t_span hi;
        t_span e;
        int    tail;
        e = s + n;
        if (free_used == 0) return table_insert(0, s, n) ? ST_DONE : ST_FULL;
        if (s < free_start[0]) begin
            if (e == free_start[0]) begin
                free_start[0] = s;
                free_len[0]   = free_len[0] + n;
                return ST_DONE;
            end
            return table_insert(0, s, n) ? ST_DONE : ST_FULL;
        end
        for (int i = 0; i + 1 < free_used; i++) begin
            lo = free_start[i] + free_len[i];
            hi = free_start[i+1];
            if (s >= lo && s < hi) begin
                if (s == lo && e == hi) begin
                    free_len[i] = free_len[i] + n + free_len[i+1];
                    table_remove(i + 1);
                end else if (s == lo) begin
                    free_len[i] = free_len[i] + n;
                end else if (e == hi) begin
                    free_start[i+1] = s;
                    free_len[i+1]   = free_len[i+1] + n;
                end else if (!table_insert(i + 1, s, n)) begin
                    return ST_FULL;
                end
                return ST_DONE;
            end
        end
        tail = free_used - 1;
        if (s == free_start[tail] + free_len[tail]) begin
            free_len[tail] = free_len[tail] + n;
            return ST_DONE;
        end
        return table_insert(free_used, s, n) ? ST_DONE : ST_FULL;
    endfunction

    function automatic t_status predict_reply(input t_cmd cmd, input logic [FIELD_W-1:0] start_req,
                                              input logic [FIELD_W-1:0] length);
        t_span s;
        t_span n;
        t_span amax;
        amax = t_span'(ADDR_MAX);
        s    = t_span'(start_req) & amax;
        n    = t_span'(length) & amax;
        // ranges are clipped one unit short of the address limit
        if (s >= amax) n = '0;
        else if (n > amax - s) n = amax - s;
        if (n == '0) return ST_DONE;
        return (cmd == CMD_FREE) ? table_free(s, n) : table_alloc(s, n);
    endfunction

    // ------------------------------------------------------------------
    // reply checker and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : reply_check
        t_reply due;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected reply: status %0d extent_count %0d",
                       rsp_bus.status, rsp_bus.extent_count);
                n_fail++;
            end else begin
                due = replies_due.pop_front();
                n_checked++;
                if (rsp_bus.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, rsp_bus.status);
                    n_fail++;
                end
                if (rsp_bus.extent_count !== due.count) begin
                    $error("extent_count: expected %0d, got %0d", due.count,
                           rsp_bus.extent_count);
                    n_fail++;
                end
            end
        end
    end

    initial begin : reply_stall
        int hold;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm_run || $urandom_range(0, 3) != 0) begin
                rsp_bus.ready <= 1'b1;
                hold = calm_run ? 1 : $urandom_range(1, 8);
            end else begin
                rsp_bus.ready <= 1'b0;
                hold = $urandom_range(1, 6);
            end
            repeat (hold - 1) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // shared tasks; each is entered just after a rising edge
    // ------------------------------------------------------------------
    task automatic send_item(input t_cmd cmd, input logic [FIELD_W-1:0] s,
                             input logic [FIELD_W-1:0] n);
        t_reply due;
        if (!calm_run && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.cmd       <= cmd;
        req_bus.start_req <= s;
        req_bus.length    <= n;
        do @(posedge i_clk); while (!req_bus.ready);
        due.status = predict_reply(cmd, s, n);
        due.count  = CNT_W'(free_used);
        replies_due.push_back(due);
        last_status = due.status;
        status_tally[due.status]++;
        n_items++;
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_pool_readback(input logic [FIELD_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= POOL_SIZE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(want)) begin
            $error("pool_size readback: expected %0d, got %0d", want, prdata);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_pool(input logic [DATA_W-1:0] word);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POOL_SIZE_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        table_load(word[FIELD_W-1:0]);
        pool_now = int'(word[FIELD_W-1:0]);
        held_ranges.delete();
        n_settings++;
        @(posedge i_clk);
        check_pool_readback(word[FIELD_W-1:0]);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // walks the allocate and free paths from the reset pool, short of a full table
    task automatic test_directed_paths();
        check_pool_readback(POOL_RESET);
        send_item(CMD_ALLOC, 24'd0, 24'd0);                    // zero length
        send_item(CMD_ALLOC, FIELD_W'(FIELD_MAX), 24'd5);      // start at the address limit
        send_item(CMD_FREE, FIELD_W'(FIELD_MAX), FIELD_W'(FIELD_MAX));
        send_item(CMD_ALLOC, 24'd100, FIELD_W'(FIELD_MAX));    // overrun clipped, trims right
        send_item(CMD_ALLOC, 24'd200, 24'd10);                 // no extent holds it
        send_item(CMD_FREE, 24'd100, 24'd50);                  // grows last extent
        send_item(CMD_FREE, 24'd300, 24'd100);                 // new extent past the end
        send_item(CMD_FREE, 24'd150, 24'd150);                 // bridges both neighbors
        send_item(CMD_ALLOC, 24'd0, 24'd10);                   // trims left
        send_item(CMD_FREE, 24'd0, 24'd10);                    // touches head from the left
        send_item(CMD_ALLOC, 24'd10, 24'd5);                   // split
        send_item(CMD_FREE, 24'd12, 24'd2);                    // new extent in a gap
        send_item(CMD_FREE, 24'd10, 24'd2);                    // fills a gap exactly
        send_item(CMD_FREE, 24'd14, 24'd1);
        send_item(CMD_ALLOC, 24'd0, 24'd400);                  // exact match, table empty
        send_item(CMD_ALLOC, 24'd5, 24'd1);                    // miss on empty table
        send_item(CMD_FREE, 24'd1000, 24'd10);                 // becomes the only extent
        send_item(CMD_FREE, 24'd5, 24'd3);                     // new head
        send_item(CMD_FREE, 24'd990, 24'd10);                  // grows next extent backward
        send_item(CMD_FREE, 24'd995, 24'd100);                 // overlaps, no merge
        send_item(CMD_FREE, 24'hFFFFF0, FIELD_W'(FIELD_MAX));  // clipped at the limit
        send_item(CMD_ALLOC, 24'hFFFFF4, 24'hFFFFFF);
        send_item(CMD_ALLOC, 24'h7FFFFF, 24'h800000);
    endtask

    // upper data bits are dropped, so this writes a zero pool
    task automatic test_empty_pool();
        write_pool(32'h5A00_0000);
        send_item(CMD_ALLOC, 24'd0, 24'd1);
        send_item(CMD_FREE, 24'd7, 24'd3);
        send_item(CMD_FREE, 24'd2, 24'd5);
        send_item(CMD_ALLOC, 24'd2, FIELD_W'(FIELD_MAX));
    endtask

    task automatic test_table_full();
        write_pool(32'd200);
        for (int k = 0; k < MAX_EXTENTS - 1; k++) send_item(CMD_ALLOC, FIELD_W'(2 * k + 1), 24'd1);
        send_item(CMD_ALLOC, 24'd127, 24'd1);    // split needs a slot
        send_item(CMD_ALLOC, 24'd126, 24'd1);    // trim needs none
        send_item(CMD_FREE, 24'd126, 24'd1);
        send_item(CMD_FREE, 24'd250, 24'd5);     // append needs a slot
        send_item(CMD_FREE, 24'd125, 24'd1);     // join frees one
        send_item(CMD_FREE, 24'd250, 24'd5);
        send_item(CMD_FREE, 24'd230, 24'd1);     // gap insert needs a slot
        send_item(CMD_FREE, 24'd255, 24'd3);
    endtask

    // mostly allocations taken from live extents and frees of earlier allocations
    task automatic test_random_mix(input logic [DATA_W-1:0] pool_word, input int count);
        int                 it;
        int                 pick;
        int                 j;
        int                 lo;
        int                 hi;
        int                 off;
        int                 avail;
        int                 want;
        int                 k;
        t_held              h;
        logic [FIELD_W-1:0] n;
        write_pool(pool_word);
        for (it = 0; it < count; it++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && free_used > 0) begin
                j     = $urandom_range(0, free_used - 1);
                lo    = int'(free_start[j]);
                hi    = lo + int'(free_len[j]);
                off   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, hi - lo - 1);
                avail = hi - lo - off;
                case ($urandom_range(0, 7))
                    0, 1:    want = avail;
                    2:       want = avail + $urandom_range(1, 50);
                    default: want = $urandom_range(1, (avail < 32) ? avail : 32);
                endcase
                if (want > FIELD_MAX) want = FIELD_MAX;
                send_item(CMD_ALLOC, FIELD_W'(lo + off), FIELD_W'(want));
                if (last_status == ST_DONE) begin
                    h.base = lo + off;
                    h.size = (want > avail) ? avail : want;
                    held_ranges.push_back(h);
                end
            end else if (pick < 75 && held_ranges.size() > 0) begin
                j = $urandom_range(0, held_ranges.size() - 1);
                h = held_ranges[j];
                if (h.size < 2 || $urandom_range(0, 2) == 0) begin
                    send_item(CMD_FREE, FIELD_W'(h.base), FIELD_W'(h.size));
                    held_ranges.delete(j);
                end else begin
                    k = $urandom_range(1, h.size - 1);
                    if ($urandom_range(0, 1) == 0) begin
                        send_item(CMD_FREE, FIELD_W'(h.base), FIELD_W'(k));
                        h.base = h.base + k;
                    end else begin
                        send_item(CMD_FREE, FIELD_W'(h.base + h.size - k), FIELD_W'(k));
                    end
                    h.size = h.size - k;
                    held_ranges[j] = h;
                end
            end else if (pick < 85) begin
                want = $urandom_range(0, pool_now + 8);
                if (want > FIELD_MAX) want = FIELD_MAX;
                send_item(CMD_ALLOC, FIELD_W'(want), FIELD_W'($urandom_range(1, 32)));
            end else begin
                case ($urandom_range(0, 7))
                    0:       n = '0;
                    1:       n = '1;
                    default: n = FIELD_W'($urandom);
                endcase
                send_item(t_cmd'($urandom_range(0, 1)), FIELD_W'($urandom), n);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        n_fail            = 0;
        n_items           = 0;
        n_checked         = 0;
        n_settings        = 0;
        status_tally      = '{0, 0, 0};
        calm_run          = 1'b0;
        pool_now          = FIELD_MAX;
        table_load(POOL_RESET);
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.cmd       <= CMD_ALLOC;
        req_bus.start_req <= '0;
        req_bus.length    <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_paths();
        test_empty_pool();
        test_table_full();
        test_random_mix(32'd1, 80);
        test_random_mix(32'd300, 100);
        test_random_mix(DATA_W'($urandom_range(2, 4096)), 100);
        test_random_mix(32'hFFFF_FFFF, 110);
        test_random_mix(DATA_W'($urandom_range(1, FIELD_MAX)), 60);
        calm_run = 1'b1;
        test_random_mix(32'd500, 100);
        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d transactions, %0d replies checked, %0d pool settings",
                 n_items, n_checked, n_settings + 1);
        $display("replies by status: done %0d, miss %0d, table full %0d",
                 status_tally[ST_DONE], status_tally[ST_MISS], status_tally[ST_FULL]);
        if (n_fail == 0) begin
            $display("free_extent_allocator_tb OK");
        end else begin
            $display("free_extent_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule
